/* rtl/core/sorted_deadline_timer_queue_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted deadline timer queue
// Shared concurrent assertion forms, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef SORTED_DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_ASSERT_SVH

// property checked outside reset
`define SDTQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("timer queue assertion failed");

// property checked at every edge, reset included
`define SDTQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("timer queue assertion failed");

`endif

/* rtl/core/sdtq_pkg.sv */
// ----------------------------------------------------------------------------
// sdtq_pkg
// Types, codes and sizes shared by the timer queue controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package sdtq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int MAX_FIRE    = 16;
   localparam int FIRE_W      = $clog2(MAX_FIRE + 1);
   localparam logic [47:0] MAX_TIME = 48'hFFFF_FFFF_FFFF;

   // function codes
   localparam logic [1:0] FN_CREATE = 2'd0;
   localparam logic [1:0] FN_CANCEL = 2'd1;
   localparam logic [1:0] FN_EXPIRE = 2'd2;
   localparam logic [1:0] FN_QUERY  = 2'd3;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_BADID    = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_NOTDUE   = 3'd4;
   localparam logic [2:0] ST_EMPTY    = 3'd5;

   typedef struct packed {
      logic [1:0]  func;
      logic [47:0] now_us;
      logic [31:0] delay_us;
      logic [31:0] cancel_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] timer_id;
      logic [47:0] time_left_us;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE, S_DISPATCH, S_CR_SCAN, S_CN_SCAN, S_EXPIRE
   } state_type;

   // which fields a result word takes
   typedef enum logic [2:0] {
      EM_ERR, EM_CREATE, EM_CANCEL, EM_FIRE, EM_QUERY
   } emit_type;

   typedef struct packed {
      logic       latch;
      logic       scan_init;
      logic       step;
      logic       insert;
      logic       remove;
      logic       pop;
      logic       emit;
      emit_type   emit_sel;
      logic [2:0] emit_status;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       full;
      logic       empty;
      logic       bad_id;
      logic       scan_end;
      logic       scan_le;
      logic       id_hit;
      logic       head_due;
      logic       fire_last;
   } stat_type;

   // time left to a deadline, clamped at zero
   function automatic logic [47:0] remain(input logic [47:0] dl, input logic [47:0] now);
      remain = (dl > now) ? dl - now : 48'd0;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/sdtq_ctrl.sv */
// ----------------------------------------------------------------------------
// sdtq_ctrl
// Sequencer: dispatches a request and walks the table one slot a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sdtq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire sdtq_pkg::stat_type stat,
   output sdtq_pkg::cmd_type      cmd
);

   sdtq_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= sdtq_pkg::S_IDLE;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != sdtq_pkg::S_IDLE);

   // next state and commands
   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      cmd.emit_sel     = sdtq_pkg::EM_ERR;
      cmd.emit_status  = sdtq_pkg::ST_OK;
      cmd.emit_last    = 1'b1;
      case (state_ff)
         sdtq_pkg::S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = sdtq_pkg::S_DISPATCH;
            end
         end
         sdtq_pkg::S_DISPATCH: begin
            state_in = sdtq_pkg::S_IDLE;
            case (stat.func)
               sdtq_pkg::FN_CREATE: begin
                  if (stat.full) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = sdtq_pkg::ST_FULL;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = sdtq_pkg::S_CR_SCAN;
                  end
               end
               sdtq_pkg::FN_CANCEL: begin
                  if (stat.bad_id) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = sdtq_pkg::ST_BADID;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = sdtq_pkg::S_CN_SCAN;
                  end
               end
               sdtq_pkg::FN_EXPIRE: begin
                  if (stat.empty) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = sdtq_pkg::ST_EMPTY;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = sdtq_pkg::S_EXPIRE;
                  end
               end
               default: begin
                  cmd.emit = 1'b1;
                  if (stat.empty) cmd.emit_status = sdtq_pkg::ST_EMPTY;
                  else            cmd.emit_sel    = sdtq_pkg::EM_QUERY;
               end
            endcase
         end
         sdtq_pkg::S_CR_SCAN: begin
            if (!stat.scan_end && stat.scan_le) begin
               cmd.step = 1'b1;
            end else begin
               cmd.insert   = 1'b1;
               cmd.emit     = 1'b1;
               cmd.emit_sel = sdtq_pkg::EM_CREATE;
               state_in     = sdtq_pkg::S_IDLE;
            end
         end
         sdtq_pkg::S_CN_SCAN: begin
            if (stat.scan_end) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = sdtq_pkg::ST_NOTFOUND;
               state_in        = sdtq_pkg::S_IDLE;
            end else if (stat.id_hit) begin
               cmd.remove   = 1'b1;
               cmd.emit     = 1'b1;
               cmd.emit_sel = sdtq_pkg::EM_CANCEL;
               state_in     = sdtq_pkg::S_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         sdtq_pkg::S_EXPIRE: begin
            cmd.emit = 1'b1;
            if (stat.head_due) begin
               cmd.pop       = 1'b1;
               cmd.emit_sel  = sdtq_pkg::EM_FIRE;
               cmd.emit_last = stat.fire_last;
               if (stat.fire_last) state_in = sdtq_pkg::S_IDLE;
            end else begin
               // only reached before the first fire
               cmd.emit_status = sdtq_pkg::ST_NOTDUE;
               state_in        = sdtq_pkg::S_IDLE;
            end
         end
         default: state_in = sdtq_pkg::S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

/* rtl/core/sdtq_datapath.sv */
// ----------------------------------------------------------------------------
// sdtq_datapath
// Sorted slot table, counters, request latch and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_deadline_timer_queue_assert.svh"
module sdtq_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sdtq_pkg::req_type req_data,
   input  wire sdtq_pkg::cmd_type cmd,
   output sdtq_pkg::stat_type     stat,
   output logic                   rsp_strobe,
   output sdtq_pkg::rsp_type      rsp_data
);

   localparam int D = sdtq_pkg::QUEUE_DEPTH;
   localparam int IDX_SEL = sdtq_pkg::IDX_W;

   logic [47:0] slot_dl_ff [D];
   logic [31:0] slot_id_ff [D];
   logic [sdtq_pkg::CNT_W-1:0]  count_ff;
   logic [31:0]                 issued_ff;
   logic [sdtq_pkg::CNT_W-1:0]  idx_ff;
   logic [sdtq_pkg::FIRE_W-1:0] fired_ff;
   logic [47:0]                 dl_ff;
   sdtq_pkg::req_type           req_ff;
   sdtq_pkg::rsp_type           rsp_ff, rsp_in;
   logic                        strobe_ff;

   logic [IDX_SEL-1:0] idx;
   logic [48:0] dl_sum;
   logic [47:0] dl_new;
   logic [47:0] sel_dl;

   assign idx    = idx_ff[IDX_SEL-1:0];
   assign dl_sum = {1'b0, req_ff.now_us} + {17'd0, req_ff.delay_us};
   assign dl_new = dl_sum[48] ? sdtq_pkg::MAX_TIME : dl_sum[47:0];
   assign sel_dl = (cmd.emit_sel == sdtq_pkg::EM_QUERY) ? slot_dl_ff[0] : slot_dl_ff[idx];

   // status towards the controller
   always_comb begin
      stat.func      = req_ff.func;
      stat.full      = (count_ff == sdtq_pkg::CNT_W'(D));
      stat.empty     = (count_ff == '0);
      stat.bad_id    = (req_ff.cancel_id > issued_ff);
      stat.scan_end  = (idx_ff == count_ff);
      stat.scan_le   = (slot_dl_ff[idx] <= dl_ff);
      stat.id_hit    = (slot_id_ff[idx] == req_ff.cancel_id);
      stat.head_due  = (fired_ff < sdtq_pkg::FIRE_W'(sdtq_pkg::MAX_FIRE))
                    && (count_ff != '0) && (slot_dl_ff[0] <= req_ff.now_us);
      stat.fire_last = (fired_ff == sdtq_pkg::FIRE_W'(sdtq_pkg::MAX_FIRE - 1))
                    || (count_ff == sdtq_pkg::CNT_W'(1))
                    || (slot_dl_ff[1] > req_ff.now_us);
   end

   // result word
   always_comb begin
      rsp_in.status       = cmd.emit_status;
      rsp_in.last         = cmd.emit_last;
      rsp_in.timer_id     = 32'd0;
      rsp_in.time_left_us = 48'd0;
      case (cmd.emit_sel)
         sdtq_pkg::EM_CREATE: rsp_in.timer_id = issued_ff + 32'd1;
         sdtq_pkg::EM_CANCEL: begin
            rsp_in.timer_id     = req_ff.cancel_id;
            rsp_in.time_left_us = sdtq_pkg::remain(sel_dl, req_ff.now_us);
         end
         sdtq_pkg::EM_FIRE:   rsp_in.timer_id = slot_id_ff[0];
         sdtq_pkg::EM_QUERY: begin
            rsp_in.timer_id     = slot_id_ff[0];
            rsp_in.time_left_us = sdtq_pkg::remain(sel_dl, req_ff.now_us);
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         issued_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
         if (cmd.insert) begin
            count_ff  <= count_ff + 1'b1;
            issued_ff <= issued_ff + 32'd1;
         end else if (cmd.remove || cmd.pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // request latch, scan pointer, fire count, result payload
   always_ff @(posedge clock) begin
      if (cmd.latch) req_ff <= req_data;
      if (cmd.scan_init) begin
         idx_ff   <= '0;
         fired_ff <= '0;
         dl_ff    <= dl_new;
      end else begin
         if (cmd.step) idx_ff   <= idx_ff + 1'b1;
         if (cmd.pop)  fired_ff <= fired_ff + 1'b1;
      end
      if (cmd.emit) rsp_ff <= rsp_in;
   end

   // slot table: shift up on insert, shift down on removal
   always_ff @(posedge clock) begin
      for (int i = 0; i < D; i++) begin
         if (cmd.insert) begin
            if (IDX_SEL'(i) == idx) begin
               slot_dl_ff[i] <= dl_ff;
               slot_id_ff[i] <= issued_ff + 32'd1;
            end else if (i > 0 && IDX_SEL'(i) > idx) begin
               slot_dl_ff[i] <= slot_dl_ff[(i > 0) ? i - 1 : 0];
               slot_id_ff[i] <= slot_id_ff[(i > 0) ? i - 1 : 0];
            end
         end else if ((cmd.remove && IDX_SEL'(i) >= idx) || cmd.pop) begin
            if (i < D - 1) begin
               slot_dl_ff[i] <= slot_dl_ff[(i < D - 1) ? i + 1 : i];
               slot_id_ff[i] <= slot_id_ff[(i < D - 1) ? i + 1 : i];
            end
         end
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   `SDTQ_ASSERT(a_count_bound, clock, reset, count_ff <= sdtq_pkg::CNT_W'(D))
   `SDTQ_ASSERT(a_insert_room, clock, reset, cmd.insert |-> count_ff < sdtq_pkg::CNT_W'(D))
   `SDTQ_ASSERT(a_pop_live, clock, reset, (cmd.pop || cmd.remove) |-> count_ff != '0)
   `SDTQ_ASSERT(a_strobe_follows, clock, reset, cmd.emit |=> rsp_strobe)

endmodule
`default_nettype wire

/* rtl/core/sorted_deadline_timer_queue.sv */
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue
// Sorted deadline timer table: create, cancel, expire and wait query.
// ----------------------------------------------------------------------------
// Create walks the table to the insert position, cancel to the match position,
// query answers at dispatch; each result word appears in the cycle after it is formed.
// Throughput: one request at a time (start is taken only while idle), with a
// one-compare-a-cycle table walk; expire emits one fired timer per cycle.
// Reset (synchronous): empties the table and restarts ids at 1.
`default_nettype none
module sorted_deadline_timer_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire sdtq_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output sdtq_pkg::rsp_type      rsp_data
);

   sdtq_pkg::cmd_type  cmd;
   sdtq_pkg::stat_type stat;

   sdtq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   sdtq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire
